// File: design/source_text_lexer_core_assert.svh
// Assertion macros for the source text lexer checks.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef SOURCE_TEXT_LEXER_CORE_ASSERT_SVH
`define SOURCE_TEXT_LEXER_CORE_ASSERT_SVH

// Same-cycle implication check.
`define STL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("source text lexer check failed");

// Next-cycle implication check.
`define STL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("source text lexer check failed");

`endif

// File: design/stl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

  // Default width of the line counter.
  localparam int LINE_BITS_DEF = 16;

  // Depth of the result queue.
  localparam int EVT_DEPTH = 4;

  // Event codes.
  localparam logic [1:0] EV_APPEND = 2'd0;
  localparam logic [1:0] EV_CLOSE  = 2'd1;
  localparam logic [1:0] EV_OP     = 2'd2;
  localparam logic [1:0] EV_BADESC = 2'd3;

  // Token types.
  localparam logic [2:0] TY_IDENT = 3'd0;
  localparam logic [2:0] TY_INT   = 3'd1;
  localparam logic [2:0] TY_DBL   = 3'd2;
  localparam logic [2:0] TY_STR   = 3'd3;
  localparam logic [2:0] TY_OP    = 3'd4;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAR   = 8'h28;
  localparam logic [7:0] CH_RPAR   = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // One token event as it leaves the block.
  typedef struct packed {
    logic [1:0]  ev;
    logic [2:0]  ty;
    logic [7:0]  ch;
    logic [15:0] line;
    logic        last;
  } evt_t;

  // Events produced by one input byte, written into the result queue.
  typedef struct packed {
    logic [1:0] cnt;
    evt_t       e0;
    evt_t       e1;
  } push_t;

endpackage

`default_nettype wire

// File: design/stl_lexer.sv
`timescale 1ns / 1ps
`default_nettype none

module stl_lexer #(
  parameter int LINE_BITS = stl_pkg::LINE_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire logic [7:0]    char_i,
  input  wire logic          end_i,
  output stl_pkg::push_t     push_o
);

  typedef enum logic [3:0] {
    M_WS,
    M_IDENT,
    M_INT,
    M_DBL,
    M_STR,
    M_ESC,
    M_PDBL,
    M_PCOM,
    M_COM
  } mode_e;

  localparam int LW = (LINE_BITS > 16) ? LINE_BITS : 16;

  mode_e                mode_q, mode_d;
  mode_e                m_eff;
  mode_e                cl_mode;
  logic [LINE_BITS-1:0] line_q, line_d, line_inc;
  logic                 dot_q, dot_d;
  logic [LW-1:0]        line_ext;
  logic [15:0]          line16;

  logic                 pre_v, cl_en, cl_v, it_v;
  stl_pkg::evt_t        pre_e, cl_e, it_e;
  logic                 in_str;

  // Line number as seen on events, and the saturating increment.
  assign line_ext = LW'(line_q);
  assign line16   = line_ext[15:0];
  assign line_inc = (line_q == '1) ? line_q : line_q + LINE_BITS'(1);

  // Event that closes whatever token is open in cl_mode, or emits a pending slash as an operator.
  always_comb begin
    cl_v = cl_en;
    cl_e = '{ev: stl_pkg::EV_CLOSE, ty: stl_pkg::TY_IDENT, ch: stl_pkg::CH_NUL,
             line: line16, last: 1'b0};
    case (cl_mode)
      M_IDENT: cl_e.ty = stl_pkg::TY_IDENT;
      M_INT:   cl_e.ty = stl_pkg::TY_INT;
      M_DBL:   cl_e.ty = stl_pkg::TY_DBL;
      M_STR, M_ESC: cl_e.ty = stl_pkg::TY_STR;
      M_PDBL:  cl_e.ty = dot_q ? stl_pkg::TY_DBL : stl_pkg::TY_OP;
      M_PCOM: begin
        cl_e.ev = stl_pkg::EV_OP;
        cl_e.ty = stl_pkg::TY_OP;
        cl_e.ch = stl_pkg::CH_SLASH;
      end
      default: cl_v = 1'b0;
    endcase
  end

  // Next-state and event selection for one byte.
  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    dot_d   = dot_q;
    pre_v   = 1'b0;
    cl_en   = 1'b0;
    it_v    = 1'b0;
    m_eff   = mode_q;
    cl_mode = mode_q;
    in_str  = 1'b0;
    pre_e = '{ev: stl_pkg::EV_OP, ty: stl_pkg::TY_OP, ch: stl_pkg::CH_SLASH,
              line: line16, last: 1'b0};
    it_e  = '{ev: stl_pkg::EV_APPEND, ty: stl_pkg::TY_IDENT, ch: char_i,
              line: line16, last: 1'b0};

    if (end_i) begin
      // Flush the open token and start afresh.
      cl_en  = 1'b1;
      mode_d = M_WS;
      dot_d  = 1'b0;
      line_d = LINE_BITS'(1);
    end else if (mode_q == M_ESC) begin
      // Escape translation inside a string.
      it_v   = 1'b1;
      mode_d = M_STR;
      case (char_i)
        stl_pkg::CH_N:      it_e.ch = stl_pkg::CH_LF;
        stl_pkg::CH_R:      it_e.ch = stl_pkg::CH_CR;
        stl_pkg::CH_T:      it_e.ch = stl_pkg::CH_TAB;
        stl_pkg::CH_BSLASH: it_e.ch = stl_pkg::CH_BSLASH;
        default:            it_e.ev = stl_pkg::EV_BADESC;
      endcase
    end else if (mode_q == M_COM) begin
      // Comment text is dropped up to the line break.
      if (char_i == stl_pkg::CH_CR || char_i == stl_pkg::CH_LF) begin
        mode_d = M_WS;
        line_d = line_inc;
      end
    end else if (mode_q == M_PCOM && char_i == stl_pkg::CH_SLASH) begin
      mode_d = M_COM;
    end else begin
      // A pending lone slash goes out first, then the byte is handled.
      pre_v   = (mode_q == M_PCOM);
      m_eff   = pre_v ? M_WS : mode_q;
      cl_mode = m_eff;
      mode_d  = m_eff;
      in_str  = (m_eff == M_STR);
      if (char_i inside {[stl_pkg::CH_ZERO:stl_pkg::CH_NINE]}) begin
        it_v = 1'b1;
        if (m_eff == M_WS) begin
          mode_d = M_INT;
        end else if (m_eff == M_PDBL) begin
          mode_d = M_DBL;
        end
      end else if (char_i == stl_pkg::CH_DOT) begin
        if (m_eff == M_WS) begin
          mode_d = M_PDBL;
          dot_d  = 1'b0;
          it_v   = 1'b1;
        end else if (m_eff == M_INT) begin
          mode_d = M_DBL;
          it_v   = 1'b1;
        end else if (in_str) begin
          it_v = 1'b1;
        end else begin
          cl_en   = 1'b1;
          mode_d  = M_WS;
          dot_d   = 1'b0;
          it_v    = 1'b1;
          it_e.ev = stl_pkg::EV_OP;
          it_e.ty = stl_pkg::TY_OP;
        end
      end else if (char_i inside {stl_pkg::CH_LBRACE, stl_pkg::CH_RBRACE,
                                  stl_pkg::CH_LPAR, stl_pkg::CH_RPAR,
                                  stl_pkg::CH_EQ, stl_pkg::CH_PLUS,
                                  stl_pkg::CH_MINUS, stl_pkg::CH_STAR,
                                  stl_pkg::CH_LT, stl_pkg::CH_SEMI,
                                  stl_pkg::CH_COMMA}) begin
        it_v = 1'b1;
        if (!in_str) begin
          cl_en   = 1'b1;
          mode_d  = M_WS;
          dot_d   = 1'b0;
          it_e.ev = stl_pkg::EV_OP;
          it_e.ty = stl_pkg::TY_OP;
        end
      end else if (char_i == stl_pkg::CH_SPACE || char_i == stl_pkg::CH_TAB) begin
        if (in_str) begin
          it_v = 1'b1;
        end else begin
          cl_en  = 1'b1;
          mode_d = M_WS;
          dot_d  = 1'b0;
        end
      end else if (char_i == stl_pkg::CH_CR || char_i == stl_pkg::CH_LF) begin
        cl_en  = 1'b1;
        mode_d = M_WS;
        dot_d  = 1'b0;
        line_d = line_inc;
      end else if (char_i == stl_pkg::CH_QUOTE) begin
        cl_en  = 1'b1;
        dot_d  = 1'b0;
        mode_d = in_str ? M_WS : M_STR;
      end else if (char_i == stl_pkg::CH_BSLASH) begin
        if (in_str) begin
          mode_d = M_ESC;
        end else begin
          cl_en   = 1'b1;
          mode_d  = M_WS;
          dot_d   = 1'b0;
          it_v    = 1'b1;
          it_e.ev = stl_pkg::EV_OP;
          it_e.ty = stl_pkg::TY_OP;
        end
      end else if (char_i == stl_pkg::CH_SLASH) begin
        if (in_str) begin
          it_v = 1'b1;
        end else begin
          cl_en  = 1'b1;
          dot_d  = 1'b0;
          mode_d = M_PCOM;
        end
      end else begin
        // Any other byte belongs to an identifier or the open token.
        it_v = 1'b1;
        if (m_eff == M_WS || m_eff == M_INT || m_eff == M_DBL) begin
          cl_en  = 1'b1;
          dot_d  = 1'b0;
          mode_d = M_IDENT;
        end else if (m_eff == M_PDBL) begin
          dot_d = 1'b1;
        end
      end
    end
  end

  // Pack the candidate events into at most two slots and mark the final one.
  always_comb begin
    push_o = '0;
    if (pre_v) begin
      push_o.e0 = pre_e;
      push_o.e1 = cl_v ? cl_e : it_e;
      push_o.cnt = (cl_v || it_v) ? 2'd2 : 2'd1;
    end else begin
      push_o.e0 = cl_v ? cl_e : it_e;
      push_o.e1 = it_e;
      push_o.cnt = 2'(cl_v) + 2'(it_v);
    end
    if (push_o.cnt == 2'd2) begin
      push_o.e1.last = 1'b1;
    end else begin
      push_o.e0.last = 1'b1;
    end
    if (!step_i) begin
      push_o.cnt = 2'd0;
    end
  end

  // Lexer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_WS;
      line_q <= LINE_BITS'(1);
      dot_q  <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      line_q <= line_d;
      dot_q  <= dot_d;
    end
  end

endmodule

`default_nettype wire

// File: design/stl_evt_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module stl_evt_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire stl_pkg::push_t push_i,
  output logic                room_o,
  input  wire logic           pop_i,
  output stl_pkg::evt_t       head_o,
  output logic                valid_o
);

  localparam int DEPTH = stl_pkg::EVT_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  stl_pkg::evt_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx;
  logic [CNT_W-1:0] count_q, count_d;

  // Room for the largest burst one byte can cause.
  assign room_o    = (count_q <= CNT_W'(DEPTH - 2));
  assign valid_o   = (count_q != '0);
  assign head_o    = mem_q[rd_ptr_q];
  assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);
  assign count_d   = count_q + CNT_W'(push_i.cnt) - CNT_W'(pop_i);

  // Entry storage, up to two writes per cycle.
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.e0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.e1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_i.cnt);
      rd_ptr_q <= rd_ptr_q + PTR_W'(pop_i);
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: design/source_text_lexer_core.sv
// Streaming source text lexer.
// The slave stream carries one source byte per request in s_axis_tdata; a
// request with s_axis_tlast high marks end of input, its byte is ignored and
// the open token is flushed. The master stream carries token events: the
// event code and token type in m_axis_tuser, the character and line number
// in m_axis_tdata, and m_axis_tlast on the final event caused by one byte.
// A request is registered on acceptance and lexed once the queue has room
// for a full burst; its zero to two events then enter a four-entry result
// queue. The first event reaches the master stream through the input
// register and the queue.
// Throughput is one byte per cycle while each byte causes at most one event
// and the receiver does not stall; a byte causing two events needs two
// transfers on the single result port draining the queue.
// Reset returns the lexer to whitespace with line one and empties the queue.
// When the receiver stalls, the queue fills and s_axis_tready drops once a
// byte waits and fewer than two entries are free; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module source_text_lexer_core #(
  parameter int LINE_BITS = stl_pkg::LINE_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  wire logic        s_axis_tlast,   // is_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] char_out, [23:8] line_number
  output logic [4:0]       m_axis_tuser,   // [1:0] event_res, [4:2] token_type
  output logic             m_axis_tlast    // last
);

  logic           in_vld_q, in_vld_d;
  logic [7:0]     in_char_q;
  logic           in_end_q;
  logic           in_take;
  logic           step;
  logic           room;
  stl_pkg::push_t push;
  stl_pkg::evt_t  head;

  // Input register moves on whenever the queue can absorb a full burst.
  assign step          = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || step;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign in_vld_d      = in_take ? 1'b1 : (step ? 1'b0 : in_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= s_axis_tdata;
      in_end_q  <= s_axis_tlast;
    end
  end

  // Lexer state machine and event generation.
  stl_lexer #(
    .LINE_BITS(LINE_BITS)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (in_char_q),
    .end_i  (in_end_q),
    .push_o (push)
  );

  // Result queue.
  stl_evt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .pop_i   (m_axis_tvalid && m_axis_tready),
    .head_o  (head),
    .valid_o (m_axis_tvalid)
  );

  // Output packing.
  assign m_axis_tdata = {head.line, head.ch};
  assign m_axis_tuser = {head.ty, head.ev};
  assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

// File: design/stl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "source_text_lexer_core_assert.svh"

module stl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [4:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);

  logic [1:0]  ev;
  logic [2:0]  ty;
  logic [7:0]  ch;
  logic        stall;
  logic [29:0] out_bus;
  logic        is_app;
  logic        is_op;
  logic        is_close;

  assign ev       = m_axis_tuser[1:0];
  assign ty       = m_axis_tuser[4:2];
  assign ch       = m_axis_tdata[7:0];
  assign stall    = m_axis_tvalid && !m_axis_tready;
  assign out_bus  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign is_app   = m_axis_tvalid
                    && (ev == stl_pkg::EV_APPEND || ev == stl_pkg::EV_BADESC);
  assign is_op    = m_axis_tvalid && (ev == stl_pkg::EV_OP);
  assign is_close = m_axis_tvalid && (ev == stl_pkg::EV_CLOSE);

  // A stalled event stays put until it is taken.
  `STL_ASSERT_NEXT(a_out_hold, stall, m_axis_tvalid && $stable(out_bus))

  // Appends and bad escapes carry no token type.
  `STL_ASSERT_IMPL(a_append_type, is_app, ty == stl_pkg::TY_IDENT)

  // Operator tokens are typed as operators.
  `STL_ASSERT_IMPL(a_op_type, is_op, ty == stl_pkg::TY_OP)

  // A close carries no character.
  `STL_ASSERT_IMPL(a_close_char, is_close, ch == stl_pkg::CH_NUL)

  // Right after reset releases the input is open and nothing comes out.
  `STL_ASSERT_IMPL(a_reset_empty, $rose(rst_ni), s_axis_tready && !m_axis_tvalid)

endmodule

bind source_text_lexer_core stl_checker u_stl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
